/* hdl/errl_pkg.sv */
package errl_pkg;

  localparam int unsigned IdW    = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CntW   = 32;
  localparam int unsigned ScrW   = 31;
  localparam int unsigned SilW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW   = 32;

  localparam logic [CntW-1:0] CountMax = '1;

  // result status codes
  localparam logic [1:0] STATUS_HANDLED = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_IGNORED = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SCRATCH_PERIOD = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SILENT_COUNT   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SILENT_TIME    = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SHOW_FIRST_N   = 2'd3;

  localparam logic [ScrW-1:0]  ScratchReset   = 31'd3600;
  localparam logic [SilW-1:0]  SilentCntReset = 16'd100;
  localparam logic [TimeW-1:0] SilentTimReset = 32'd60;
  localparam logic [SilW-1:0]  FirstNReset    = 16'd0;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] last_update;
    logic [TimeW-1:0] last_printed;
    logic [CntW-1:0]  threshold;
    logic [CntW-1:0]  repeats;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic alloc;
    logic calc1;
    logic calc2;
    logic set_ignored;
    logic set_full;
    logic load_out;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic enabled;
    logic hit;
    logic scan_done;
    logic table_full;
  } dp_sts_t;

endpackage

/* hdl/errl_ctrl.sv */
module errl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  errl_pkg::dp_sts_t sts,
  output errl_pkg::dp_cmd_t cmd
);
  import errl_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_CALC1  = 5'b00100,
    S_CALC2  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (!sts.enabled) begin
          cmd.set_ignored = 1'b1;
          state_next      = S_FINISH;
        end else if (sts.hit) begin
          state_next = S_CALC1;
        end else if (sts.scan_done) begin
          if (sts.table_full) begin
            cmd.set_full = 1'b1;
            state_next   = S_FINISH;
          end else begin
            cmd.alloc  = 1'b1;
            state_next = S_CALC1;
          end
        end
      end
      S_CALC1: begin
        cmd.calc1  = 1'b1;
        state_next = S_CALC2;
      end
      S_CALC2: begin
        cmd.calc2  = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/errl_dp.sv */
module errl_dp #(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [errl_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [errl_pkg::CfgW-1:0]         cfg_data,
  input  logic [errl_pkg::IdW-1:0]          error_id,
  input  logic [errl_pkg::TimeW-1:0]        now_seconds,
  input  logic                              enabled,
  input  errl_pkg::dp_cmd_t                 cmd,
  output errl_pkg::dp_sts_t                 sts,
  output logic [1:0]                        status,
  output logic                              show,
  output logic                              first_occurrence,
  output logic                              show_count_suffix,
  output logic [errl_pkg::CntW-1:0]         repeat_count
);
  import errl_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  // configuration
  logic [ScrW-1:0]  scratch_period;
  logic [SilW-1:0]  silent_count;
  logic [TimeW-1:0] silent_time;
  logic [SilW-1:0]  show_first_n;

  // captured word
  logic [IdW-1:0]   cur_id;
  logic [TimeW-1:0] cur_now;
  logic             cur_en;

  // table
  entry_t           mem [MAX_ENTRIES];
  entry_t           rdata;
  logic [CW-1:0]    entry_count;
  logic [CW-1:0]    scan_ptr;
  logic             cmp_valid;
  logic [AW-1:0]    cmp_idx;
  logic             issue;

  // working entry
  entry_t           ent;
  logic [AW-1:0]    ent_idx;

  // first calc stage
  logic [CntW-1:0]  rep;
  logic [CntW-1:0]  thr;
  logic [TimeW-1:0] lp;
  logic             time_ok;

  // pending result
  logic [1:0]       res_status;
  logic             res_show;
  logic             res_first;
  logic             res_suffix;
  logic [CntW-1:0]  res_count;

  // stage-one combinational terms
  logic [CntW-1:0]  rep1;
  logic [TimeW-1:0] diff;
  logic             quiet;
  logic [CntW-1:0]  rep_q;
  logic [CntW-1:0]  thr_q;
  logic [TimeW-1:0] lp_q;

  // stage-two terms
  logic             is_one;
  logic             show_c;
  logic [CntW:0]    thr_sum;
  logic [CntW-1:0]  thr_new;
  logic             ext;

  assign issue = cmd.scan && (scan_ptr < entry_count);

  assign sts.enabled    = cur_en;
  assign sts.hit        = cmp_valid && (rdata.id == cur_id);
  assign sts.scan_done  = (scan_ptr >= entry_count) && !cmp_valid;
  assign sts.table_full = (entry_count == CW'(MAX_ENTRIES));

  always_comb begin
    rep1    = (ent.repeats == CountMax) ? CountMax : ent.repeats + 1'b1;
    diff    = cur_now - ent.last_update;
    quiet   = !diff[TimeW-1] && (diff > {1'b0, scratch_period});
    rep_q   = (quiet && rep1 > 1) ? CntW'(1) : rep1;
    thr_q   = quiet ? '0 : ent.threshold;
    lp_q    = quiet ? '0 : ent.last_printed;
  end

  always_comb begin
    is_one  = (rep == CntW'(1));
    show_c  = is_one || (rep <= {{(CntW-SilW){1'b0}}, show_first_n}) ||
              ((rep >= thr) && time_ok);
    thr_sum = {1'b0, rep} + {{(CntW+1-SilW){1'b0}}, silent_count};
    if (is_one) begin
      thr_new = {{(CntW-SilW){1'b0}}, silent_count};
    end else if (thr_sum[CntW]) begin
      thr_new = CountMax;
    end else begin
      thr_new = thr_sum[CntW-1:0];
    end
    ext = (silent_count > SilW'(1)) || (silent_time != '0);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scratch_period <= ScratchReset;
      silent_count   <= SilentCntReset;
      silent_time    <= SilentTimReset;
      show_first_n   <= FirstNReset;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SCRATCH_PERIOD: scratch_period <= cfg_data[ScrW-1:0];
        REG_SILENT_COUNT:   silent_count   <= cfg_data[SilW-1:0];
        REG_SILENT_TIME:    silent_time    <= cfg_data[TimeW-1:0];
        REG_SHOW_FIRST_N:   show_first_n   <= cfg_data[SilW-1:0];
        default: ;
      endcase
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      scan_ptr    <= '0;
      cmp_valid   <= 1'b0;
    end else begin
      cmp_valid <= issue;
      if (cmd.start) begin
        scan_ptr <= '0;
      end else if (issue) begin
        scan_ptr <= scan_ptr + 1'b1;
      end
      if (cmd.alloc) begin
        entry_count <= entry_count + 1'b1;
      end
    end
  end

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (issue) begin
      rdata <= mem[scan_ptr[AW-1:0]];
    end
    if (cmd.calc2) begin
      mem[ent_idx] <= '{id: cur_id, last_update: cur_now,
                        last_printed: show_c ? cur_now : lp,
                        threshold: show_c ? thr_new : thr, repeats: rep};
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmp_idx <= scan_ptr[AW-1:0];
    if (cmd.start) begin
      cur_id  <= error_id;
      cur_now <= now_seconds;
      cur_en  <= enabled;
    end
    if (cmd.scan && sts.hit) begin
      ent     <= rdata;
      ent_idx <= cmp_idx;
    end else if (cmd.alloc) begin
      ent     <= '{id: cur_id, last_update: cur_now, last_printed: '0,
                   threshold: '0, repeats: '0};
      ent_idx <= entry_count[AW-1:0];
    end
    if (cmd.calc1) begin
      rep     <= rep_q;
      thr     <= thr_q;
      lp      <= lp_q;
      time_ok <= (cur_now - lp_q) >= silent_time;
    end
    if (cmd.set_ignored || cmd.set_full) begin
      res_status <= cmd.set_full ? STATUS_FULL : STATUS_IGNORED;
      res_show   <= 1'b0;
      res_first  <= 1'b0;
      res_suffix <= 1'b0;
      res_count  <= '0;
    end else if (cmd.calc2) begin
      res_status <= STATUS_HANDLED;
      res_show   <= show_c;
      res_first  <= is_one;
      res_suffix <= show_c && !is_one && ext;
      res_count  <= rep;
    end
    if (cmd.load_out) begin
      status            <= res_status;
      show              <= res_show;
      first_occurrence  <= res_first;
      show_count_suffix <= res_suffix;
      repeat_count      <= res_count;
    end
  end

endmodule

/* hdl/error_event_rate_limiter_core.sv */
// Error event rate limiter: one result word per input word.
// The search ends at the slot that holds the id; a new id or a full table
// scans every stored entry; a disabled word skips the search.
// One word at a time, searched through the entry table one slot per cycle.
// Reset (rst, synchronous): table empty, config registers at default values.
module error_event_rate_limiter_core #(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_write,
  input  logic [errl_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [errl_pkg::CfgW-1:0]     cfg_data,
  // event words
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [errl_pkg::IdW-1:0]      error_id,
  input  logic [errl_pkg::TimeW-1:0]    now_seconds,
  input  logic                          enabled,
  // result words
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic                          show,
  output logic                          first_occurrence,
  output logic                          show_count_suffix,
  output logic [errl_pkg::CntW-1:0]     repeat_count
);
  import errl_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: idle -> scan -> two calc steps -> finish (or scan -> finish).
  // The finish state waits only for the output register, so a new word
  // can be taken while the previous result still sits unread.
  errl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: entry table (one write, one registered read per cycle),
  // pipelined id compare, two-step update arithmetic, output register.
  errl_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .error_id          (error_id),
    .now_seconds       (now_seconds),
    .enabled           (enabled),
    .cmd               (cmd),
    .sts               (sts),
    .status            (status),
    .show              (show),
    .first_occurrence  (first_occurrence),
    .show_count_suffix (show_count_suffix),
    .repeat_count      (repeat_count)
  );

endmodule
